// ----- hdl/ppwt_pkg.sv -----
// Shared constants, codes and helper functions for the pure pursuit waypoint target block.
// Depends on nothing; imported by pure_pursuit_waypoint_target.
`default_nettype none

package ppwt_pkg;

	localparam int COORD_W  = 32;
	localparam int SLOT_W   = 8;
	localparam int LOOK_W   = 31;
	localparam int TOTAL_W  = 9;
	localparam int DEPTH    = 256;

	// Approach tolerance of 0.25 in Q16.16.
	localparam logic [32:0] NEAR_TOL = 33'd16384;
	// Saturation limit of coordinate differences.
	localparam logic signed [32:0] DIFF_LIM = 33'sd2147483647;
	// Upper limit of the interpolation factor, 2^32.
	localparam logic [63:0] T_LIM = 64'h0000_0001_0000_0000;

	// Input word opcodes.
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_QUERY   = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic [0:0] CFG_LOOKAHEAD = 1'b0;
	localparam logic [0:0] CFG_TOTAL     = 1'b1;

	// Saturate a 33-bit difference to +-(2^31-1).
	function automatic logic signed [31:0] sat_diff(input logic signed [32:0] d);
		logic signed [31:0] r;
		if (d > DIFF_LIM) begin
			r = 32'sh7FFF_FFFF;
		end else if (d < -DIFF_LIM) begin
			r = -32'sh7FFF_FFFF;
		end else begin
			r = d[31:0];
		end
		return r;
	endfunction

	// Magnitude of a 33-bit signed difference.
	function automatic logic [32:0] mag33(input logic signed [32:0] d);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	// Magnitude of a saturated difference, which never holds -2^31.
	function automatic logic [31:0] mag32(input logic signed [31:0] d);
		return d[31] ? 32'(-d) : 32'(d);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pure_pursuit_waypoint_target.sv -----
// Pure pursuit waypoint target: loads waypoints, walks segments and places the pursuit target.
// Approach and last-waypoint queries read one waypoint; a tracking query tests waypoints against the
// lookahead, then runs the 32-step square root and the two 64-step bit-serial divisions, which a
// zero-length segment skips. Loads and restarts stay in the idle state, so they never stall the
// input; a finished result waits in the finishing state until the output register is free.
// Reset clears state and registers, but not the waypoint memory, its read data or the product.
`default_nettype none

module pure_pursuit_waypoint_target
	import ppwt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Configuration write port
	input  wire logic                      cfg_we,
	input  wire logic [0:0]                cfg_index,
	input  wire logic [LOOK_W-1:0]         cfg_data,
	// Request channel
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic [1:0]                opcode,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	input  wire logic signed [COORD_W-1:0] coord_z,
	// Response channel
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output logic signed [COORD_W-1:0]      target_x,
	output logic signed [COORD_W-1:0]      target_y,
	output logic signed [COORD_W-1:0]      target_z,
	output logic signed [COORD_W-1:0]      heading_x,
	output logic signed [COORD_W-1:0]      heading_y,
	output logic signed [COORD_W-1:0]      heading_z,
	output logic [SLOT_W-1:0]              segment_now,
	output logic                           approaching
);

	typedef enum logic [4:0] {
		S_IDLE, S_APP_RD, S_APP_CHK, S_LAST_RD, S_LAST,
		S_CL_RD, S_CL0, S_CL1, S_CL2, S_CL3, S_CL4, S_CL5,
		S_SG_RDA, S_SG_A, S_SG_RDB, S_SG_B,
		S_LN0, S_LN1, S_LN2, S_LN3, S_DT0, S_DT1, S_DT2,
		S_SQ, S_DV, S_DV_END, S_T0, S_T1, S_T2, S_FIN
	} state_t;

	state_t state_q;

	// Configuration and tracking state.
	logic [LOOK_W-1:0]  look_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SLOT_W-1:0]  seg_q, j_q, n1_q, addr_q;
	logic               app_q;
	logic               rsp_valid_q;

	// Query position and segment data.
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [31:0] p1_q [3];
	logic signed [31:0] e_q [3];
	logic signed [31:0] qx_q, qy_q;
	logic [32:0]        ax_q, ay_q, az_q;
	logic               far_q;

	// Shared multiplier and accumulators.
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q, acc_q, tmp_q;
	logic signed [63:0] dot_q;

	// Square root and divider.
	logic [63:0] sv_q, sr_q, dq_q;
	logic [32:0] rem_q;
	logic [31:0] len_q;
	logic [5:0]  cnt_q;
	logic        dneg_q, dpass_q;
	logic [32:0] tmag_q;
	logic        tneg_q;
	logic [1:0]  axis_q;

	// Result holding registers.
	logic signed [31:0] tgt_q [3];
	logic signed [31:0] hd_q [3];

	// Waypoint memory: z, y, x packed in one word.
	logic [95:0] mem [DEPTH];
	logic [95:0] rd_q;
	logic signed [31:0] wx, wy, wz;

	logic req_acc;
	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign wx = rd_q[31:0];
	assign wy = rd_q[63:32];
	assign wz = rd_q[95:64];

	// Memory: loads write at acceptance, reads are registered and return data in the cycle after the address.
	always_ff @(posedge clk) begin
		if (req_acc && opcode == OP_LOAD) begin
			mem[slot] <= {coord_z, coord_y, coord_x};
		end
		rd_q <= mem[addr_q];
	end

	// Clamped waypoint count minus one.
	logic [8:0] n_c, n1_c;
	logic [7:0] j0_c;
	always_comb begin
		if (total_q < 9'd2) begin
			n_c = 9'd2;
		end else if (total_q > 9'd256) begin
			n_c = 9'd256;
		end else begin
			n_c = total_q;
		end
		n1_c = n_c - 9'd1;
		j0_c = (seg_q == 8'd0) ? 8'd1 : seg_q;
	end

	// Axis-selected segment operands for the target stage.
	logic signed [31:0] e_ax;
	always_comb begin
		unique case (axis_q)
			2'd0:    e_ax = e_q[0];
			2'd1:    e_ax = e_q[1];
			default: e_ax = e_q[2];
		endcase
	end

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_CL1:   begin mul_a = ax_q[31:0]; mul_b = ax_q[31:0]; end
			S_CL2:   begin mul_a = ay_q[31:0]; mul_b = ay_q[31:0]; end
			S_CL3:   begin mul_a = az_q[31:0]; mul_b = az_q[31:0]; end
			S_CL4:   begin mul_a = {1'b0, look_q}; mul_b = {1'b0, look_q}; end
			S_LN0:   begin mul_a = mag32(e_q[0]); mul_b = mag32(e_q[0]); end
			S_LN1:   begin mul_a = mag32(e_q[1]); mul_b = mag32(e_q[1]); end
			S_LN2:   begin mul_a = mag32(e_q[2]); mul_b = mag32(e_q[2]); end
			S_DT0:   begin mul_a = mag32(e_q[0]); mul_b = mag32(qx_q); end
			S_DT1:   begin mul_a = mag32(e_q[1]); mul_b = mag32(qy_q); end
			S_T0:    begin mul_a = {16'd0, tmag_q[15:0]}; mul_b = mag32(e_ax); end
			S_T1:    begin mul_a = {15'd0, tmag_q[32:16]}; mul_b = mag32(e_ax); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	function automatic logic signed [31:0] p1_sel(input logic [1:0] k);
		logic signed [31:0] r;
		unique case (k)
			2'd0:    r = p1_q[0];
			2'd1:    r = p1_q[1];
			default: r = p1_q[2];
		endcase
		return r;
	endfunction

	// Datapath helpers for the current state.
	logic signed [32:0] dx_c, dy_c, dz_c;
	logic [32:0]        adx_c, ady_c, adz_c;
	logic [63:0]        sq_bit, sq_try;
	logic [63:0]        sr_nx;
	logic [32:0]        rem_sh;
	logic               dv_ge;
	logic signed [35:0] proj_c, sum_c;
	logic [35:0]        sum_mag;
	logic [63:0]        m_c;
	logic signed [65:0] tsum_c;
	logic signed [31:0] tsat_c;
	logic               tsgn_c;
	logic [7:0]         jn_c;

	always_comb begin
		dx_c   = {cx_q[31], cx_q} - {wx[31], wx};
		dy_c   = {cy_q[31], cy_q} - {wy[31], wy};
		dz_c   = {cz_q[31], cz_q} - {wz[31], wz};
		adx_c  = mag33(dx_c);
		ady_c  = mag33(dy_c);
		adz_c  = mag33(dz_c);
		sq_bit = 64'd1 << {cnt_q[4:0], 1'b0};
		sq_try = sr_q + sq_bit;
		sr_nx  = (sv_q >= sq_try) ? ((sr_q >> 1) + sq_bit) : (sr_q >> 1);
		rem_sh = {rem_q[31:0], dq_q[63]};
		dv_ge  = (rem_sh >= {1'b0, len_q});
		proj_c = dneg_q ? -$signed({1'b0, dq_q[34:0]}) : $signed({1'b0, dq_q[34:0]});
		sum_c  = $signed({5'd0, look_q}) + proj_c;
		sum_mag = sum_c[35] ? 36'(-sum_c) : 36'(sum_c);
		m_c    = prod_q + tmp_q;
		tsgn_c = tneg_q ^ e_ax[31];
		tsum_c = 66'(p1_sel(axis_q)) + (tsgn_c ? -$signed({2'b0, m_c}) : $signed({2'b0, m_c}));
		if (tsum_c > 66'sh7FFF_FFFF) begin
			tsat_c = 32'sh7FFF_FFFF;
		end else if (tsum_c < -66'sh8000_0000) begin
			tsat_c = 32'sh8000_0000;
		end else begin
			tsat_c = tsum_c[31:0];
		end
		jn_c = j_q + 8'd1;
	end

	// Sequencer with state, datapath and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			look_q      <= 31'd65536;
			total_q     <= 9'd2;
			seg_q       <= '0;
			app_q       <= 1'b1;
			rsp_valid_q <= 1'b0;
			j_q         <= '0;
			n1_q        <= '0;
			addr_q      <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			p1_q        <= '{default: '0};
			e_q         <= '{default: '0};
			qx_q        <= '0;
			qy_q        <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			az_q        <= '0;
			far_q       <= 1'b0;
			acc_q       <= '0;
			tmp_q       <= '0;
			dot_q       <= '0;
			sv_q        <= '0;
			sr_q        <= '0;
			dq_q        <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			dneg_q      <= 1'b0;
			dpass_q     <= 1'b0;
			tmag_q      <= '0;
			tneg_q      <= 1'b0;
			axis_q      <= '0;
			tgt_q       <= '{default: '0};
			hd_q        <= '{default: '0};
			target_x    <= '0;
			target_y    <= '0;
			target_z    <= '0;
			heading_x   <= '0;
			heading_y   <= '0;
			heading_z   <= '0;
			segment_now <= '0;
			approaching <= 1'b0;
		end else begin
			// Configuration writes.
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LOOKAHEAD: look_q  <= cfg_data;
					CFG_TOTAL:     total_q <= cfg_data[TOTAL_W-1:0];
					default:       look_q  <= look_q;
				endcase
			end

			// A taken response word frees the output register unless a new one replaces it.
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						cx_q <= coord_x;
						cy_q <= coord_y;
						cz_q <= coord_z;
						n1_q <= n1_c[7:0];
						if (opcode == OP_RESTART) begin
							seg_q <= '0;
							app_q <= 1'b1;
						end else if (opcode == OP_QUERY) begin
							if (app_q) begin
								addr_q  <= '0;
								state_q <= S_APP_RD;
							end else if ({1'b0, j0_c} >= n1_c) begin
								addr_q  <= n1_c[7:0];
								state_q <= S_LAST_RD;
							end else begin
								j_q     <= j0_c;
								addr_q  <= j0_c;
								state_q <= S_CL_RD;
							end
						end
					end
				end

				S_APP_RD: state_q <= S_APP_CHK;

				// Approach: target waypoint 0, leave approach once within tolerance.
				S_APP_CHK: begin
					tgt_q <= '{wx, wy, wz};
					hd_q  <= '{default: '0};
					if (adx_c <= NEAR_TOL && ady_c <= NEAR_TOL && adz_c <= NEAR_TOL) begin
						app_q <= 1'b0;
						seg_q <= 8'd1;
					end
					state_q <= S_FIN;
				end

				S_LAST_RD: state_q <= S_LAST;

				// Last waypoint reached: hold there with zero heading.
				S_LAST: begin
					tgt_q   <= '{wx, wy, wz};
					hd_q    <= '{default: '0};
					seg_q   <= n1_q;
					state_q <= S_FIN;
				end

				S_CL_RD: state_q <= S_CL0;

				// Lookahead test of waypoint j: box check first, then squared distance.
				S_CL0: begin
					ax_q    <= adx_c;
					ay_q    <= ady_c;
					az_q    <= adz_c;
					far_q   <= (adx_c >= {2'b0, look_q}) || (ady_c >= {2'b0, look_q})
						|| (adz_c >= {2'b0, look_q});
					state_q <= S_CL1;
				end

				S_CL1: begin
					if (far_q) begin
						addr_q  <= j_q - 8'd1;
						state_q <= S_SG_RDA;
					end else begin
						state_q <= S_CL2;
					end
				end

				S_CL2: begin
					acc_q   <= prod_q;
					state_q <= S_CL3;
				end

				S_CL3: begin
					acc_q   <= acc_q + prod_q;
					state_q <= S_CL4;
				end

				S_CL4: begin
					acc_q   <= acc_q + prod_q;
					state_q <= S_CL5;
				end

				S_CL5: begin
					if (acc_q < prod_q) begin
						j_q <= jn_c;
						if (jn_c == n1_q) begin
							addr_q  <= j_q;
							state_q <= S_SG_RDA;
						end else begin
							addr_q  <= jn_c;
							state_q <= S_CL_RD;
						end
					end else begin
						addr_q  <= j_q - 8'd1;
						state_q <= S_SG_RDA;
					end
				end

				S_SG_RDA: state_q <= S_SG_A;

				S_SG_A: begin
					p1_q    <= '{wx, wy, wz};
					addr_q  <= j_q;
					state_q <= S_SG_RDB;
				end

				S_SG_RDB: state_q <= S_SG_B;

				// Segment direction and position offset, saturated.
				S_SG_B: begin
					e_q[0]  <= sat_diff({wx[31], wx} - {p1_q[0][31], p1_q[0]});
					e_q[1]  <= sat_diff({wy[31], wy} - {p1_q[1][31], p1_q[1]});
					e_q[2]  <= sat_diff({wz[31], wz} - {p1_q[2][31], p1_q[2]});
					qx_q    <= sat_diff({cx_q[31], cx_q} - {p1_q[0][31], p1_q[0]});
					qy_q    <= sat_diff({cy_q[31], cy_q} - {p1_q[1][31], p1_q[1]});
					state_q <= S_LN0;
				end

				S_LN0: state_q <= S_LN1;

				S_LN1: begin
					acc_q   <= prod_q;
					state_q <= S_LN2;
				end

				S_LN2: begin
					acc_q   <= acc_q + prod_q;
					state_q <= S_LN3;
				end

				// Squared length done; the square root starts after the dot product.
				S_LN3: begin
					sv_q    <= acc_q + prod_q;
					sr_q    <= '0;
					cnt_q   <= 6'd31;
					state_q <= S_DT0;
				end

				S_DT0: state_q <= S_DT1;

				S_DT1: begin
					dot_q   <= (e_q[0][31] ^ qx_q[31]) ? -$signed(prod_q) : $signed(prod_q);
					state_q <= S_DT2;
				end

				S_DT2: begin
					dot_q   <= dot_q + ((e_q[1][31] ^ qy_q[31]) ? -$signed(prod_q)
						: $signed(prod_q));
					state_q <= S_SQ;
				end

				// Integer square root, one result bit a cycle.
				S_SQ: begin
					if (sv_q >= sq_try) begin
						sv_q <= sv_q - sq_try;
					end
					sr_q <= sr_nx;
					if (cnt_q == 6'd0) begin
						len_q <= sr_nx[31:0];
						if (sr_nx == 64'd0) begin
							tmag_q  <= '0;
							tneg_q  <= 1'b0;
							axis_q  <= '0;
							state_q <= S_T0;
						end else begin
							dq_q    <= dot_q[63] ? 64'(-dot_q) : 64'(dot_q);
							dneg_q  <= dot_q[63];
							dpass_q <= 1'b0;
							rem_q   <= '0;
							cnt_q   <= 6'd63;
							state_q <= S_DV;
						end
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end

				// Restoring division by the segment length, one quotient bit a cycle.
				S_DV: begin
					rem_q <= dv_ge ? (rem_sh - {1'b0, len_q}) : rem_sh;
					dq_q  <= {dq_q[62:0], dv_ge};
					if (cnt_q == 6'd0) begin
						state_q <= S_DV_END;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end

				S_DV_END: begin
					if (!dpass_q) begin
						// Projection known: divide (lookahead + projection) * 2^16 again.
						dq_q    <= {12'd0, sum_mag, 16'd0};
						dneg_q  <= sum_c[35];
						dpass_q <= 1'b1;
						rem_q   <= '0;
						cnt_q   <= 6'd63;
						state_q <= S_DV;
					end else begin
						tmag_q  <= (dq_q > T_LIM) ? T_LIM[32:0] : dq_q[32:0];
						tneg_q  <= dneg_q;
						axis_q  <= '0;
						state_q <= S_T0;
					end
				end

				S_T0: state_q <= S_T1;

				S_T1: begin
					tmp_q   <= prod_q >> 16;
					state_q <= S_T2;
				end

				// Target coordinate p1 + t*d / 2^16 for one axis.
				S_T2: begin
					tgt_q[axis_q] <= tsat_c;
					if (axis_q == 2'd2) begin
						hd_q    <= e_q;
						seg_q   <= j_q;
						state_q <= S_FIN;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_T0;
					end
				end

				// Hand the result to the output register once it is free.
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						target_x    <= tgt_q[0];
						target_y    <= tgt_q[1];
						target_z    <= tgt_q[2];
						heading_x   <= hd_q[0];
						heading_y   <= hd_q[1];
						heading_z   <= hd_q[2];
						segment_now <= seg_q;
						approaching <= app_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A new response word appears only out of the finishing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response raised outside the finishing state");

	// Tracking mode always has a segment index of at least one.
	assert property (@(posedge clk) disable iff (!arst_n)
		!app_q |-> seg_q != 8'd0)
		else $error("tracking with segment index zero");

	// The divider never runs with a zero segment length.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DV |-> len_q != 32'd0)
		else $error("division by zero length");

	// The interpolation factor stays within its saturation limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_T0 |-> {31'd0, tmag_q} <= T_LIM)
		else $error("interpolation factor out of range");

endmodule

`default_nettype wire
